// ----- design/bmhq_pkg.sv -----
// Shared types and codes for the binary min-heap priority queue.
package bmhq_pkg;

  // Operation codes carried by the kind field
  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One heap slot: priority key and entry tag
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath commands
  typedef struct packed {
    logic accept;       // input transfer: latch item, set up first step
    logic rd_parent;    // read parent of pos on port A
    logic rd_children;  // read left child on port A, right on port B
    logic ex_load;      // take root as result, last slot as moving item
    logic wr_item;      // write moving item at pos
    logic climb;        // move parent down into pos, pos <= parent
    logic descend;      // move smaller child up into pos, pos <= child
    logic out_load;     // load output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic req_insert;   // pending input is an insert
    logic full;         // heap holds CAPACITY entries
    logic empty;        // heap holds no entries
    logic pos_zero;     // hole is at the root
    logic parent_gt;    // parent key strictly greater than item key
    logic lc_in;        // left child of pos lies inside the heap
    logic child_lt;     // some child key strictly smaller than item key
    logic last_one;     // heap holds exactly one entry
    logic out_free;     // output register can take a result
  } dp_status_t;

endpackage

// ----- design/bmhq_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module bmhq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- design/bmhq_ctrl.sv -----
// Sequencing state machine for heap insert and extract.
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_UP_RD   = 7'b0000010,
    S_UP_CMP  = 7'b0000100,
    S_EX_LOAD = 7'b0001000,
    S_DN_RD   = 7'b0010000,
    S_DN_CMP  = 7'b0100000,
    S_FIN     = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // No transfer is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (st.req_insert) begin
            state_next = st.full ? S_FIN : S_UP_RD;
          end else begin
            state_next = st.empty ? S_FIN : S_EX_LOAD;
          end
        end
      end
      S_UP_RD: begin
        if (st.pos_zero) begin
          cmd.wr_item = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.parent_gt) begin
          cmd.climb  = 1'b1;
          state_next = S_UP_RD;
        end else begin
          cmd.wr_item = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_EX_LOAD: begin
        cmd.ex_load = 1'b1;
        state_next  = st.last_one ? S_FIN : S_DN_RD;
      end
      S_DN_RD: begin
        if (!st.lc_in) begin
          cmd.wr_item = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.rd_children = 1'b1;
          state_next      = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (st.child_lt) begin
          cmd.descend = 1'b1;
          state_next  = S_DN_RD;
        end else begin
          cmd.wr_item = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // An accepted item always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state != S_IDLE)
    else $error("accepted item did not start work");

  // Compare steps follow their read steps
  a_up_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_UP_CMP |-> $past(state) == S_UP_RD)
    else $error("sift-up compare without parent read");

  a_dn_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_DN_CMP |-> $past(state) == S_DN_RD)
    else $error("sift-down compare without child read");

endmodule

// ----- design/bmhq_dp.sv -----
// Heap datapath: slot memory, count, hole position, moving item, result.
module bmhq_dp
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  st,
  input  logic        kind,
  input  logic [15:0] entry_tag,
  input  logic [31:0] priority_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_tag,
  output logic [31:0] out_priority,
  output logic [1:0]  status,
  output logic [8:0]  occupancy
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  entry_t        item;
  entry_t        res;
  logic [1:0]    res_status;

  entry_t        rd_a, rd_b;
  logic [ENTRY_W-1:0] rdata_a, rdata_b;

  logic          we;
  entry_t        wdata;
  logic [AW-1:0] raddr_a, raddr_b;

  logic [CW-1:0] count_m1;
  logic [AW-1:0] parent;
  logic [XW-1:0] lc, rc, count_x;
  logic          lc_in, rc_in, l_lt, r_lt;
  logic [31:0]   best_key;
  logic [8:0]    count_occ;

  assign rd_a = entry_t'(rdata_a);
  assign rd_b = entry_t'(rdata_b);

  // Heap index arithmetic
  assign count_m1 = count - 1'b1;
  assign parent   = (pos - 1'b1) >> 1;
  assign lc       = {1'b0, pos, 1'b1};
  assign rc       = lc + 1'b1;
  assign count_x  = XW'(count);
  assign lc_in    = lc < count_x;
  assign rc_in    = rc < count_x;

  // Sift-down pick: left on strict less, then right on strict less
  assign l_lt     = lc_in && (rd_a.key < item.key);
  assign best_key = l_lt ? rd_a.key : item.key;
  assign r_lt     = rc_in && (rd_b.key < best_key);

  // Status to controller
  always_comb begin
    st            = '0;
    st.req_insert = (kind == KIND_INSERT);
    st.full       = (count == CW'(CAPACITY));
    st.empty      = (count == '0);
    st.pos_zero   = (pos == '0);
    st.parent_gt  = (rd_a.key > item.key);
    st.lc_in      = lc_in;
    st.child_lt   = l_lt || r_lt;
    st.last_one   = (count == CW'(1));
    st.out_free   = !out_valid || out_ready;
  end

  // Memory port steering; outside sift reads, fetch root and last slot
  always_comb begin
    we = cmd.wr_item || cmd.climb || cmd.descend;
    if (cmd.wr_item) begin
      wdata = item;
    end else if (cmd.climb) begin
      wdata = rd_a;
    end else begin
      wdata = r_lt ? rd_b : rd_a;
    end
    if (cmd.rd_parent) begin
      raddr_a = parent;
      raddr_b = rc[AW-1:0];
    end else if (cmd.rd_children) begin
      raddr_a = lc[AW-1:0];
      raddr_b = rc[AW-1:0];
    end else begin
      raddr_a = '0;
      raddr_b = count_m1[AW-1:0];
    end
  end

  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (pos),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept && st.req_insert && !st.full) begin
      count <= count + 1'b1;
    end else if (cmd.ex_load) begin
      count <= count_m1;
    end
  end

  // Hole position, moving item and pending result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item.key <= priority_req;
      item.tag <= entry_tag;
      res      <= '0;
      pos      <= count[AW-1:0];
      if (st.req_insert) begin
        res_status <= st.full ? ST_FULL : ST_OK;
      end else begin
        res_status <= st.empty ? ST_EMPTY : ST_OK;
      end
    end else if (cmd.ex_load) begin
      res  <= rd_a;
      item <= rd_b;
      pos  <= '0;
    end else if (cmd.climb) begin
      pos <= parent;
    end else if (cmd.descend) begin
      pos <= r_lt ? rc[AW-1:0] : lc[AW-1:0];
    end
  end

  // Output register
  assign count_occ = 9'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tag      <= res.tag;
      out_priority <= res.key;
      status       <= res_status;
      occupancy    <= count_occ;
    end
  end

  // Every slot write lands inside the live heap
  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    we |-> XW'(pos) < count_x)
    else $error("heap write beyond entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

endmodule

// ----- design/binary_min_heap_queue_core.sv -----
// An insert climbs by parent read and compare steps until the parent key is not greater or the
// hole is at the root; an extract loads root and last slot, then descends by child read and
// compare steps unless one entry was left. A full insert or an extract on empty skips the sift.
// One item is in work at a time; in_ready returns the cycle after the result is loaded, and a
// result waiting in the output register holds the next item in its final step.
// Reset (rst, synchronous) empties the heap and output register, holds in_ready low; RAM kept.
module binary_min_heap_queue_core
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] entry_tag,
  input  logic [31:0] priority_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_tag,
  output logic [31:0] out_priority,
  output logic [1:0]  status,
  output logic [8:0]  occupancy
);

  dp_cmd_t    cmd;
  dp_status_t st;

  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .kind         (kind),
    .entry_tag    (entry_tag),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_tag      (out_tag),
    .out_priority (out_priority),
    .status       (status),
    .occupancy    (occupancy)
  );

endmodule
